FILE: rtl/apcs_pkg.sv
// shared types, constants and codes for the airspeed pressure smoother
package apcs_pkg;

  // status codes of a result item
  localparam logic [1:0] ST_REJECT = 2'd0;
  localparam logic [1:0] ST_CAL    = 2'd1;
  localparam logic [1:0] ST_VALID  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_HIGH  = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration reset values
  localparam logic [15:0] ALPHA_MIN_RST = 16'd3277;
  localparam logic [15:0] ALPHA_MAX_RST = 16'd32768;
  localparam logic [13:0] DEV_LOW_RST   = 14'd2;
  localparam logic [13:0] DEV_HIGH_RST  = 14'd40;

  // calibration counts
  localparam logic [8:0] CAL_DONE_COUNT = 9'd256;
  localparam logic [8:0] CAL_SUM_START  = 9'd128;

  // largest reportable smoothed value
  localparam logic [21:0] SMOOTH_MAX = 22'h3FFFFF;

  // rounding constant for the Q0.16 step
  localparam logic signed [41:0] Q16_HALF = 42'sd32768;

  // queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // gain interpolation divider
  localparam int unsigned DIV_NUM_W   = 38;
  localparam int unsigned DIV_DEN_W   = 22;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // configuration register set
  typedef struct packed {
    logic [15:0] alpha_min;
    logic [15:0] alpha_max;
    logic [13:0] dev_low;
    logic [13:0] dev_high;
  } cfg_t;

  // classified frame: good flag and centred 14-bit count (two's complement)
  typedef struct packed {
    logic        good;
    logic [13:0] centred;
  } item_t;

endpackage

FILE: rtl/apcs_front.sv
// front end: accepts sensor frames, flags them good or bad on status and centres the count
module apcs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_status_pressure_hi,
  input  logic [7:0]           in_pressure_lo,
  output logic                 q_valid,
  output apcs_pkg::item_t      q_item,
  input  logic                 q_ready
);
  import apcs_pkg::*;

  logic  front_valid_r, front_valid_nxt;
  item_t front_item_r;
  item_t classified;

  // status bits reject the frame; subtracting 0x2000 flips count bit 13
  always_comb begin
    classified.good    = (in_status_pressure_hi[7:6] == 2'b00);
    classified.centred = {~in_status_pressure_hi[5], in_status_pressure_hi[4:0],
                          in_pressure_lo};
  end

  assign in_ready = !front_valid_r || q_ready;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_valid && in_ready) begin
      front_valid_nxt = 1'b1;
    end else if (q_ready) begin
      front_valid_nxt = 1'b0;
    end
  end

  // holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      front_item_r <= classified;
    end
  end

  assign q_valid = front_valid_r;
  assign q_item  = front_item_r;

endmodule

FILE: rtl/apcs_queue.sv
// short item queue between the front end and the back end
module apcs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  apcs_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output apcs_pkg::item_t pop_item,
  input  logic            pop
);
  import apcs_pkg::*;

  item_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = q_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/apcs_div.sv
// restoring divider for the gain interpolation, one quotient bit per cycle
module apcs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [apcs_pkg::DIV_NUM_W-1:0] num,
  input  logic [apcs_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [apcs_pkg::DIV_STEPS-1:0] quot
);
  import apcs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] shq_r, shq_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W+1:0] trial;
  logic                 ge;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {1'b0, rem_r, shq_r[DIV_STEPS-1]} - {2'b00, den_r};
  assign ge    = !trial[DIV_DEN_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    shq_nxt  = shq_r;
    den_nxt  = den_r;
    if (start) begin
      // quotient fits in DIV_STEPS bits, so the top part is below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[DIV_NUM_W-1:DIV_STEPS];
      shq_nxt  = num[DIV_STEPS-1:0];
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[DIV_DEN_W-1:0] : {rem_r[DIV_DEN_W-2:0], shq_r[DIV_STEPS-1]};
      shq_nxt = {shq_r[DIV_STEPS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shq_r <= shq_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = shq_r;

endmodule

FILE: rtl/apcs_back.sv
// back end: calibration, adaptive gain and smoother update, result register
module apcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  apcs_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  apcs_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [21:0]     out_diff_pressure
);
  import apcs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DEV   = 12'b0000_0000_0010,
    S_ABS   = 12'b0000_0000_0100,
    S_SEL   = 12'b0000_0000_1000,
    S_MUL   = 12'b0000_0001_0000,
    S_DIVS  = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_ALPHA = 12'b0000_1000_0000,
    S_STEP  = 12'b0001_0000_0000,
    S_RND   = 12'b0010_0000_0000,
    S_SUM   = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // model state
  logic               calibrated_r, calibrated_nxt;
  logic [8:0]         cal_count_r, cal_count_nxt;
  logic signed [21:0] cal_sum_r, cal_sum_nxt;
  logic signed [21:0] zero_off_r, zero_off_nxt;
  logic [21:0]        smoothed_r, smoothed_nxt;

  // working registers
  logic signed [23:0] sample_r, sample_nxt;
  logic signed [24:0] diff_r, diff_nxt;
  logic [23:0]        dev_r, dev_nxt;
  logic [15:0]        amag_r, amag_nxt;
  logic               aneg_r, aneg_nxt;
  logic [21:0]        off_r, off_nxt;
  logic [21:0]        span_r, span_nxt;
  logic [37:0]        prod_r, prod_nxt;
  logic [15:0]        alpha_r, alpha_nxt;
  logic signed [41:0] prod2_r, prod2_nxt;
  logic signed [25:0] step_r, step_nxt;
  logic signed [26:0] sum_r, sum_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [21:0]        out_diff_r, out_diff_nxt;

  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [15:0]        div_quot;
  logic [8:0]         cnt_inc;
  logic [21:0]        low8;
  logic [21:0]        high8;
  logic [24:0]        diff_neg;
  logic [23:0]        dev_less_low;
  logic signed [41:0] rnd;
  logic [26:0]        sum_mag;
  logic [21:0]        sat;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid &&
                     (out_free || (q_item.good && calibrated_r));
  assign div_start = (state_r == S_DIVS);
  assign cnt_inc   = cal_count_r + 1'b1;
  assign low8      = {cfg.dev_low, 8'h00};
  assign high8     = {cfg.dev_high, 8'h00};
  assign diff_neg  = -diff_r;
  assign dev_less_low = dev_r - {2'b00, low8};
  assign rnd       = prod2_r + Q16_HALF;
  assign sum_mag   = sum_r[26] ? -sum_r : sum_r;
  assign sat       = (sum_mag > {5'b0, SMOOTH_MAX}) ? SMOOTH_MAX : sum_mag[21:0];

  apcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (span_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer and datapath
  always_comb begin
    state_nxt      = state_r;
    calibrated_nxt = calibrated_r;
    cal_count_nxt  = cal_count_r;
    cal_sum_nxt    = cal_sum_r;
    zero_off_nxt   = zero_off_r;
    smoothed_nxt   = smoothed_r;
    sample_nxt     = sample_r;
    diff_nxt       = diff_r;
    dev_nxt        = dev_r;
    amag_nxt       = amag_r;
    aneg_nxt       = aneg_r;
    off_nxt        = off_r;
    span_nxt       = span_r;
    prod_nxt       = prod_r;
    alpha_nxt      = alpha_r;
    prod2_nxt      = prod2_r;
    step_nxt       = step_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_diff_nxt   = out_diff_r;

    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (!q_item.good) begin
            // rejected frame leaves all state alone
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_REJECT;
            out_diff_nxt   = '0;
          end else if (!calibrated_r) begin
            // calibration: skip the first frames, sum the next, then take the mean
            cal_count_nxt = cnt_inc;
            if (cnt_inc == CAL_DONE_COUNT) begin
              zero_off_nxt   = {cal_sum_r[20:0], 1'b0};
              calibrated_nxt = 1'b1;
            end else if (cnt_inc >= CAL_SUM_START) begin
              cal_sum_nxt = cal_sum_r + {{8{q_item.centred[13]}}, q_item.centred};
            end
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_CAL;
            out_diff_nxt   = '0;
          end else begin
            // offset-corrected sample in Q.8
            sample_nxt = {{2{q_item.centred[13]}}, q_item.centred, 8'h00} -
                         {{2{zero_off_r[21]}}, zero_off_r};
            state_nxt  = S_DEV;
          end
        end
      end
      S_DEV: begin
        diff_nxt  = {sample_r[23], sample_r} - {3'b000, smoothed_r};
        state_nxt = S_ABS;
      end
      S_ABS: begin
        dev_nxt   = diff_r[24] ? diff_neg[23:0] : diff_r[23:0];
        state_nxt = S_SEL;
      end
      S_SEL: begin
        // gain clamps first, else prepare the interpolation
        amag_nxt = (cfg.alpha_max >= cfg.alpha_min) ? cfg.alpha_max - cfg.alpha_min
                                                     : cfg.alpha_min - cfg.alpha_max;
        aneg_nxt = (cfg.alpha_max < cfg.alpha_min);
        off_nxt  = dev_less_low[21:0];
        span_nxt = high8 - low8;
        if (dev_r <= {2'b00, low8}) begin
          alpha_nxt = cfg.alpha_min;
          state_nxt = S_STEP;
        end else if (dev_r >= {2'b00, high8}) begin
          alpha_nxt = cfg.alpha_max;
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = amag_r * off_r;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_ALPHA;
        end
      end
      S_ALPHA: begin
        // quotient stays below the gain span, so no wrap
        alpha_nxt = aneg_r ? cfg.alpha_min - div_quot : cfg.alpha_min + div_quot;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        prod2_nxt = $signed({1'b0, alpha_r}) * diff_r;
        state_nxt = S_RND;
      end
      S_RND: begin
        // round to nearest, ties upward
        step_nxt  = rnd[41:16];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = {5'b00000, smoothed_r} + {step_r[25], step_r};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          smoothed_nxt   = sat;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_VALID;
          out_diff_nxt   = sat;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      calibrated_r <= 1'b0;
      cal_count_r  <= '0;
      cal_sum_r    <= '0;
      zero_off_r   <= '0;
      smoothed_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      calibrated_r <= calibrated_nxt;
      cal_count_r  <= cal_count_nxt;
      cal_sum_r    <= cal_sum_nxt;
      zero_off_r   <= zero_off_nxt;
      smoothed_r   <= smoothed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    diff_r       <= diff_nxt;
    dev_r        <= dev_nxt;
    amag_r       <= amag_nxt;
    aneg_r       <= aneg_nxt;
    off_r        <= off_nxt;
    span_r       <= span_nxt;
    prod_r       <= prod_nxt;
    alpha_r      <= alpha_nxt;
    prod2_r      <= prod2_nxt;
    step_r       <= step_nxt;
    sum_r        <= sum_nxt;
    out_status_r <= out_status_nxt;
    out_diff_r   <= out_diff_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_diff_pressure = out_diff_r;

endmodule

FILE: rtl/airspeed_pressure_calib_smoother.sv
// top level: configuration registers, front end, queue and back end
// rejected and calibrating frames pass the front holding register, the queue and the result register
// smoothed frames step through DEV, ABS, SEL, STEP, RND, SUM and FIN, adding MUL, DIVS, DIV, ALPHA if interpolated
// the back end takes no new frame until the current smoothed frame has left S_FIN
// throughput: rejected and calibrating frames pass at one per cycle while out_ready is high and the back end is idle
// reset: synchronous active low, clears calibration, smoother and registers to defaults
module airspeed_pressure_calib_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_status_pressure_hi,
  input  logic [7:0]                         in_pressure_lo,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic [21:0]                        out_diff_pressure,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [apcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import apcs_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  fq_valid;
  item_t fq_item;
  logic  fq_ready;
  logic  qb_valid;
  item_t qb_item;
  logic  qb_pop;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA_MIN: cfg_nxt.alpha_min = cfg_data;
        CFG_ALPHA_MAX: cfg_nxt.alpha_max = cfg_data;
        CFG_DEV_LOW:   cfg_nxt.dev_low   = cfg_data[13:0];
        CFG_DEV_HIGH:  cfg_nxt.dev_high  = cfg_data[13:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_min <= ALPHA_MIN_RST;
      cfg_r.alpha_max <= ALPHA_MAX_RST;
      cfg_r.dev_low   <= DEV_LOW_RST;
      cfg_r.dev_high  <= DEV_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apcs_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_status_pressure_hi (in_status_pressure_hi),
    .in_pressure_lo        (in_pressure_lo),
    .q_valid               (fq_valid),
    .q_item                (fq_item),
    .q_ready               (fq_ready)
  );

  apcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_item  (fq_item),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_item   (qb_item),
    .pop        (qb_pop)
  );

  apcs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (qb_valid),
    .q_item            (qb_item),
    .q_pop             (qb_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_diff_pressure (out_diff_pressure)
  );

endmodule

FILE: rtl/apcs_checker.sv
// port-level checks on the result channel, bound to the top level
module apcs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [21:0] out_diff_pressure
);
  import apcs_pkg::*;

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_REJECT || out_status == ST_CAL ||
                   out_status == ST_VALID))
    else $error("undefined status code on result");

  // rejected and calibrating results carry no pressure
  a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_VALID) |-> (out_diff_pressure == '0))
    else $error("pressure nonzero on a non-valid result");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_diff_pressure)))
    else $error("result changed while stalled");

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind airspeed_pressure_calib_smoother apcs_checker u_apcs_checker (.*);
